FILE: hdl/running_moment_statistics_top_assert.svh
// Assertion macros for the running moment statistics block.
// Included by the top level; no other dependencies.
`ifndef RUNNING_MOMENT_STATISTICS_TOP_ASSERT_SVH
`define RUNNING_MOMENT_STATISTICS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define RMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define RMS_ASSERT(lbl, clk, rstn, prop)
`define RMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/rms_pkg.sv
// Types, constants and the micro-op table of the running moment statistics block.
// No dependencies; used by the stream interfaces and the top level.
package rms_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned MASK_W   = 6;

  localparam logic [MASK_W-1:0] MASK_RESET = 6'd4;
  localparam logic [63:0] THREE_Q32 = 64'h0000_0003_0000_0000;
  localparam logic [63:0] POS_MAX   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_MIN   = 64'h8000_0000_0000_0000;

  typedef enum logic [CODE_W-1:0] {
    STAT_KURT  = 3'd0,
    STAT_SKEW  = 3'd1,
    STAT_AVG   = 3'd2,
    STAT_SDEV  = 3'd3,
    STAT_VAR   = 3'd4,
    STAT_COUNT = 3'd5
  } stat_e;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_ISSUE = 10'b00_0000_0010,
    ST_MUL   = 10'b00_0000_0100,
    ST_MRND  = 10'b00_0000_1000,
    ST_DIV   = 10'b00_0001_0000,
    ST_DRND  = 10'b00_0010_0000,
    ST_SQRT  = 10'b00_0100_0000,
    ST_PACK  = 10'b00_1000_0000,
    ST_WB    = 10'b01_0000_0000,
    ST_EMIT  = 10'b10_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_SQRT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_32 = 2'd2,
    SH_48 = 2'd3
  } shift_e;

  typedef enum logic [4:0] {
    SRC_X, SRC_MEAN, SRC_M2, SRC_M3, SRC_M4, SRC_DELTA, SRC_DN, SRC_DN2,
    SRC_T1, SRC_TA, SRC_TB, SRC_TC, SRC_TD, SRC_PV, SRC_SP, SRC_VAR,
    SRC_CNT, SRC_CP1, SRC_CM1, SRC_CNT3, SRC_C3, SRC_C4, SRC_C6, SRC_THREE
  } src_e;

  typedef enum logic [3:0] {
    DST_DELTA, DST_DN, DST_DN2, DST_T1, DST_TA, DST_TB, DST_TC, DST_TD,
    DST_M2, DST_M3, DST_M4, DST_MEAN, DST_PV, DST_SP, DST_VAR, DST_SDEV
  } dst_e;

  typedef struct packed {
    op_e    op;
    src_e   a;
    src_e   b;
    shift_e sh;
    dst_e   dst;
  } uop_t;

  typedef logic [5:0] step_t;

  localparam step_t STEP_ACC_LAST  = 6'd23;
  localparam step_t STEP_OUT_FIRST = 6'd24;
  localparam step_t STEP_OUT_LAST  = 6'd32;

  function automatic uop_t mk(op_e op, src_e a, src_e b, shift_e sh, dst_e dst);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.sh  = sh;
    u.dst = dst;
    return u;
  endfunction

  function automatic uop_t uop_at(step_t s);
    uop_t u;
    unique case (s)
      6'd0:  u = mk(OP_SUB,  SRC_X,     SRC_MEAN,  SH_0,  DST_DELTA);
      6'd1:  u = mk(OP_DIV,  SRC_DELTA, SRC_CP1,   SH_0,  DST_DN);
      6'd2:  u = mk(OP_MUL,  SRC_DN,    SRC_DN,    SH_48, DST_DN2);
      6'd3:  u = mk(OP_MUL,  SRC_DELTA, SRC_DN,    SH_48, DST_TA);
      6'd4:  u = mk(OP_MUL,  SRC_TA,    SRC_CNT,   SH_0,  DST_T1);
      6'd5:  u = mk(OP_MUL,  SRC_CP1,   SRC_CP1,   SH_0,  DST_TD);
      6'd6:  u = mk(OP_SUB,  SRC_TD,    SRC_CNT3,  SH_0,  DST_TD);
      6'd7:  u = mk(OP_MUL,  SRC_T1,    SRC_DN2,   SH_16, DST_TA);
      6'd8:  u = mk(OP_MUL,  SRC_TA,    SRC_TD,    SH_0,  DST_TA);
      6'd9:  u = mk(OP_MUL,  SRC_DN2,   SRC_M2,    SH_16, DST_TB);
      6'd10: u = mk(OP_MUL,  SRC_TB,    SRC_C6,    SH_0,  DST_TB);
      6'd11: u = mk(OP_ADD,  SRC_TA,    SRC_TB,    SH_0,  DST_TC);
      6'd12: u = mk(OP_MUL,  SRC_DN,    SRC_M3,    SH_32, DST_TB);
      6'd13: u = mk(OP_MUL,  SRC_TB,    SRC_C4,    SH_0,  DST_TB);
      6'd14: u = mk(OP_SUB,  SRC_TC,    SRC_TB,    SH_0,  DST_TC);
      6'd15: u = mk(OP_MUL,  SRC_T1,    SRC_DN,    SH_32, DST_TA);
      6'd16: u = mk(OP_MUL,  SRC_TA,    SRC_CM1,   SH_0,  DST_TA);
      6'd17: u = mk(OP_MUL,  SRC_DN,    SRC_M2,    SH_32, DST_TB);
      6'd18: u = mk(OP_MUL,  SRC_TB,    SRC_C3,    SH_0,  DST_TB);
      6'd19: u = mk(OP_SUB,  SRC_TA,    SRC_TB,    SH_0,  DST_TA);
      6'd20: u = mk(OP_ADD,  SRC_M4,    SRC_TC,    SH_0,  DST_M4);
      6'd21: u = mk(OP_ADD,  SRC_M3,    SRC_TA,    SH_0,  DST_M3);
      6'd22: u = mk(OP_ADD,  SRC_M2,    SRC_T1,    SH_0,  DST_M2);
      6'd23: u = mk(OP_ADD,  SRC_MEAN,  SRC_DN,    SH_0,  DST_MEAN);
      6'd24: u = mk(OP_DIV,  SRC_M2,    SRC_CM1,   SH_16, DST_VAR);
      6'd25: u = mk(OP_SQRT, SRC_VAR,   SRC_VAR,   SH_0,  DST_SDEV);
      6'd26: u = mk(OP_DIV,  SRC_M2,    SRC_CNT,   SH_16, DST_PV);
      6'd27: u = mk(OP_SQRT, SRC_PV,    SRC_PV,    SH_0,  DST_SP);
      6'd28: u = mk(OP_DIV,  SRC_M4,    SRC_M2,    SH_32, DST_TA);
      6'd29: u = mk(OP_DIV,  SRC_TA,    SRC_PV,    SH_32, DST_TA);
      6'd30: u = mk(OP_SUB,  SRC_TA,    SRC_THREE, SH_0,  DST_TC);
      6'd31: u = mk(OP_DIV,  SRC_M3,    SRC_M2,    SH_32, DST_TB);
      6'd32: u = mk(OP_DIV,  SRC_TB,    SRC_SP,    SH_32, DST_TD);
      default: u = mk(OP_ADD, SRC_TA,   SRC_TA,    SH_0,  DST_TA);
    endcase
    return u;
  endfunction

endpackage

FILE: hdl/rms_stream_if.sv
// Valid/ready stream interfaces for sample items and result items.
// Depends on rms_pkg for the field widths.
interface rms_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [rms_pkg::SAMPLE_W-1:0] sample_value;
  logic                                window_last;

  modport source (output valid, output sample_value, output window_last, input ready);
  modport sink   (input valid, input sample_value, input window_last, output ready);
endinterface

interface rms_result_if;
  logic                               valid;
  logic                               ready;
  logic        [rms_pkg::CODE_W-1:0]  stat_code;
  logic signed [rms_pkg::VALUE_W-1:0] stat_value;
  logic                               result_last;

  modport source (output valid, output stat_code, output stat_value, output result_last,
                  input ready);
  modport sink   (input valid, input stat_code, input stat_value, input result_last,
                  output ready);
endinterface

FILE: hdl/running_moment_statistics_top.sv
// Running mean, variance, skewness and kurtosis over windows of Q16.16 samples.
// One sample item is taken at a time; the block is not ready until it has been folded
// in. Each sample runs 24 micro-ops on one shared arithmetic unit: a multiply sums four
// 32x32 partial products, a divide yields one quotient bit a cycle (64 plus the fraction
// shift) and an add is written back directly. The item that closes a window adds six
// divides and two square roots, then walks the six statistic codes and clears the
// window, waiting while the receiver stalls.
// Depends on rms_pkg, rms_stream_if and running_moment_statistics_top_assert.svh.
`include "running_moment_statistics_top_assert.svh"

module running_moment_statistics_top #(
  parameter int unsigned MAX_WINDOW = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rms_pkg::MASK_W-1:0]   cfg_wdata_i,
  rms_sample_if.sink                   smp_i,
  rms_result_if.source                 res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);

  rms_pkg::state_e state_q, state_d;
  rms_pkg::step_t  step_q, step_d;
  rms_pkg::uop_t   uop;
  rms_pkg::shift_e sh_q;

  logic [rms_pkg::MASK_W-1:0] mask_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [6:0]                 it_q;
  logic [2:0]                 code_q;
  logic                       last_q;
  logic [63:0] mean_q, m2_q, m3_q, m4_q;
  logic [31:0] x_q;
  logic [63:0] delta_q, dn_q, dn2_q, t1_q, ta_q, tb_q, tc_q, td_q;
  logic [63:0] pv_q, sp_q, var_q, sdev_q, res_q;

  logic [63:0]  ma_q, mb_q, rem_q, root_q;
  logic [127:0] acc_q, num_q, rad_q;
  logic [67:0]  srem_q;
  logic         neg_q;

  logic                       out_valid_q, out_last_q;
  logic [rms_pkg::CODE_W-1:0] out_code_q;
  logic [63:0]                out_value_q;

  logic [63:0]  opa, opb, mag_a, mag_b, cnt_ext, add_res, sub_res;
  logic [64:0]  add65, sub65;
  logic [5:0]   sh_amt;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [127:0] pp_ext, rnd;
  logic [63:0]  div_sh;
  logic         div_ge;
  logic [67:0]  sq_rem, sq_trial;
  logic         sq_ge;
  logic [63:0]  root_nx;
  logic [5:0]   mask_hi;
  logic         emit_free, emit_fire, kurt_ok, skew_ok;
  logic [63:0]  emit_val;

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] sat65(logic [64:0] r);
    if (r[64] != r[63]) return r[64] ? rms_pkg::NEG_MIN : rms_pkg::POS_MAX;
    return r[63:0];
  endfunction

  function automatic logic [63:0] pack_sat(logic neg, logic [127:0] m);
    logic over;
    over = (|m[127:64]) || m[63];
    if (neg) return over ? rms_pkg::NEG_MIN : (~m[63:0] + 64'd1);
    return over ? rms_pkg::POS_MAX : m[63:0];
  endfunction

  function automatic logic [5:0] sh_amt_of(rms_pkg::shift_e s);
    return {s, 4'd0};
  endfunction

  function automatic logic [63:0] pick(rms_pkg::src_e s);
    logic [63:0] v;
    unique case (s)
      rms_pkg::SRC_X:     v = {{16{x_q[31]}}, x_q, 16'd0};
      rms_pkg::SRC_MEAN:  v = mean_q;
      rms_pkg::SRC_M2:    v = m2_q;
      rms_pkg::SRC_M3:    v = m3_q;
      rms_pkg::SRC_M4:    v = m4_q;
      rms_pkg::SRC_DELTA: v = delta_q;
      rms_pkg::SRC_DN:    v = dn_q;
      rms_pkg::SRC_DN2:   v = dn2_q;
      rms_pkg::SRC_T1:    v = t1_q;
      rms_pkg::SRC_TA:    v = ta_q;
      rms_pkg::SRC_TB:    v = tb_q;
      rms_pkg::SRC_TC:    v = tc_q;
      rms_pkg::SRC_TD:    v = td_q;
      rms_pkg::SRC_PV:    v = pv_q;
      rms_pkg::SRC_SP:    v = sp_q;
      rms_pkg::SRC_VAR:   v = var_q;
      rms_pkg::SRC_CNT:   v = cnt_ext;
      rms_pkg::SRC_CP1:   v = cnt_ext + 64'd1;
      rms_pkg::SRC_CM1:   v = cnt_ext - 64'd1;
      rms_pkg::SRC_CNT3:  v = (cnt_ext << 1) + cnt_ext;
      rms_pkg::SRC_C3:    v = 64'd3;
      rms_pkg::SRC_C4:    v = 64'd4;
      rms_pkg::SRC_C6:    v = 64'd6;
      rms_pkg::SRC_THREE: v = rms_pkg::THREE_Q32;
      default:            v = '0;
    endcase
    return v;
  endfunction

  assign uop     = rms_pkg::uop_at(step_q);
  assign cnt_ext = 64'(cnt_q);
  assign opa     = pick(uop.a);
  assign opb     = pick(uop.b);
  assign mag_a   = mag64(opa);
  assign mag_b   = mag64(opb);
  assign add65   = {opa[63], opa} + {opb[63], opb};
  assign sub65   = {opa[63], opa} - {opb[63], opb};
  assign add_res = sat65(add65);
  assign sub_res = sat65(sub65);
  assign sh_amt  = {sh_q, 4'd0};

  assign pp     = 64'(it_q[1] ? ma_q[63:32] : ma_q[31:0])
                * 64'(it_q[0] ? mb_q[63:32] : mb_q[31:0]);
  assign pp_pos = {1'b0, it_q[1]} + {1'b0, it_q[0]};
  assign pp_ext = {64'd0, pp} << {pp_pos, 5'd0};
  assign rnd    = (sh_q == rms_pkg::SH_0) ? '0 : (128'd1 << (sh_amt - 6'd1));

  assign div_sh = {rem_q[62:0], num_q[127]};
  assign div_ge = rem_q[63] || (div_sh >= mb_q);

  assign sq_rem   = {srem_q[65:0], rad_q[127:126]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;
  assign root_nx  = {root_q[62:0], sq_ge};

  assign mask_hi   = mask_q >> code_q;
  assign emit_free = !out_valid_q || res_o.ready;
  assign emit_fire = (state_q == rms_pkg::ST_EMIT) && (code_q <= 3'(rms_pkg::STAT_COUNT))
                     && emit_free && mask_q[code_q];
  assign skew_ok   = !m2_q[63] && (m2_q != '0);
  assign kurt_ok   = skew_ok && (pv_q != '0);

  always_comb begin
    case (code_q)
      rms_pkg::STAT_KURT:  emit_val = kurt_ok ? tc_q : '0;
      rms_pkg::STAT_SKEW:  emit_val = skew_ok ? td_q : '0;
      rms_pkg::STAT_AVG:   emit_val = mean_q;
      rms_pkg::STAT_SDEV:  emit_val = sdev_q;
      rms_pkg::STAT_VAR:   emit_val = var_q;
      rms_pkg::STAT_COUNT: emit_val = cnt_ext << 32;
      default:             emit_val = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      rms_pkg::ST_IDLE: begin
        if (smp_i.valid) begin
          if (cnt_q != CNT_MAX) begin
            step_d  = '0;
            state_d = rms_pkg::ST_ISSUE;
          end else if (smp_i.window_last) begin
            step_d  = rms_pkg::STEP_OUT_FIRST;
            state_d = rms_pkg::ST_ISSUE;
          end
        end
      end
      rms_pkg::ST_ISSUE: begin
        unique case (uop.op) inside
          rms_pkg::OP_MUL:  state_d = rms_pkg::ST_MUL;
          rms_pkg::OP_DIV:  state_d = (mag_b == '0) ? rms_pkg::ST_WB : rms_pkg::ST_DIV;
          rms_pkg::OP_SQRT: state_d = (opa[63] || opa == '0) ? rms_pkg::ST_WB
                                                              : rms_pkg::ST_SQRT;
          rms_pkg::OP_ADD, rms_pkg::OP_SUB: state_d = rms_pkg::ST_WB;
          default:          state_d = rms_pkg::ST_WB;
        endcase
      end
      rms_pkg::ST_MUL:  if (it_q[1:0] == 2'd3) state_d = rms_pkg::ST_MRND;
      rms_pkg::ST_MRND: state_d = rms_pkg::ST_PACK;
      rms_pkg::ST_DIV:  if (it_q == '0) state_d = rms_pkg::ST_DRND;
      rms_pkg::ST_DRND: state_d = rms_pkg::ST_PACK;
      rms_pkg::ST_SQRT: if (it_q == '0) state_d = rms_pkg::ST_WB;
      rms_pkg::ST_PACK: state_d = rms_pkg::ST_WB;
      rms_pkg::ST_WB: begin
        if (step_q == rms_pkg::STEP_ACC_LAST) begin
          if (last_q) begin
            step_d  = rms_pkg::STEP_OUT_FIRST;
            state_d = rms_pkg::ST_ISSUE;
          end else begin
            state_d = rms_pkg::ST_IDLE;
          end
        end else if (step_q == rms_pkg::STEP_OUT_LAST) begin
          state_d = rms_pkg::ST_EMIT;
        end else begin
          step_d  = step_q + 6'd1;
          state_d = rms_pkg::ST_ISSUE;
        end
      end
      rms_pkg::ST_EMIT: if (code_q > 3'(rms_pkg::STAT_COUNT)) state_d = rms_pkg::ST_IDLE;
      default: state_d = rms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rms_pkg::ST_IDLE;
      step_q      <= '0;
      mask_q      <= rms_pkg::MASK_RESET;
      cnt_q       <= '0;
      it_q        <= '0;
      code_q      <= '0;
      last_q      <= 1'b0;
      mean_q      <= '0;
      m2_q        <= '0;
      m3_q        <= '0;
      m4_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (emit_fire) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        rms_pkg::ST_IDLE: if (smp_i.valid) last_q <= smp_i.window_last;
        rms_pkg::ST_ISSUE: begin
          case (uop.op)
            rms_pkg::OP_MUL:  it_q <= '0;
            rms_pkg::OP_DIV:  it_q <= 7'd63 + 7'(sh_amt_of(uop.sh));
            rms_pkg::OP_SQRT: it_q <= 7'd47;
            default:          it_q <= it_q;
          endcase
        end
        rms_pkg::ST_MUL:  it_q <= it_q + 7'd1;
        rms_pkg::ST_DIV, rms_pkg::ST_SQRT: if (it_q != '0) it_q <= it_q - 7'd1;
        rms_pkg::ST_WB: begin
          case (uop.dst)
            rms_pkg::DST_M2:   m2_q   <= res_q;
            rms_pkg::DST_M3:   m3_q   <= res_q;
            rms_pkg::DST_M4:   m4_q   <= res_q;
            rms_pkg::DST_MEAN: mean_q <= res_q;
            default: ;
          endcase
          if (step_q == rms_pkg::STEP_ACC_LAST) cnt_q <= cnt_q + CNT_W'(1);
          code_q <= '0;
        end
        rms_pkg::ST_EMIT: begin
          if (code_q > 3'(rms_pkg::STAT_COUNT)) begin
            cnt_q  <= '0;
            mean_q <= '0;
            m2_q   <= '0;
            m3_q   <= '0;
            m4_q   <= '0;
          end else if (emit_free) begin
            code_q <= code_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rms_pkg::ST_IDLE: if (smp_i.valid) x_q <= smp_i.sample_value;
      rms_pkg::ST_ISSUE: begin
        sh_q  <= uop.sh;
        neg_q <= opa[63] ^ opb[63];
        case (uop.op)
          rms_pkg::OP_ADD: res_q <= add_res;
          rms_pkg::OP_SUB: res_q <= sub_res;
          rms_pkg::OP_MUL: begin
            ma_q  <= mag_a;
            mb_q  <= mag_b;
            acc_q <= '0;
          end
          rms_pkg::OP_DIV: begin
            num_q <= {mag_a, 64'd0};
            mb_q  <= mag_b;
            rem_q <= '0;
            acc_q <= '0;
            res_q <= '0;
          end
          rms_pkg::OP_SQRT: begin
            rad_q  <= {opa, 64'd0};
            srem_q <= '0;
            root_q <= '0;
            res_q  <= '0;
          end
          default: res_q <= '0;
        endcase
      end
      rms_pkg::ST_MUL:  acc_q <= acc_q + pp_ext;
      rms_pkg::ST_MRND: acc_q <= (acc_q + rnd) >> sh_amt;
      rms_pkg::ST_DIV: begin
        num_q <= {num_q[126:0], 1'b0};
        rem_q <= div_ge ? (div_sh - mb_q) : div_sh;
        acc_q <= {acc_q[126:0], div_ge};
      end
      rms_pkg::ST_DRND: acc_q <= acc_q + 128'(rem_q >= (mb_q - rem_q));
      rms_pkg::ST_SQRT: begin
        rad_q  <= {rad_q[125:0], 2'b00};
        srem_q <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
        root_q <= root_nx;
        if (it_q == '0) res_q <= root_nx;
      end
      rms_pkg::ST_PACK: res_q <= pack_sat(neg_q, acc_q);
      rms_pkg::ST_WB: begin
        case (uop.dst)
          rms_pkg::DST_DELTA: delta_q <= res_q;
          rms_pkg::DST_DN:    dn_q    <= res_q;
          rms_pkg::DST_DN2:   dn2_q   <= res_q;
          rms_pkg::DST_T1:    t1_q    <= res_q;
          rms_pkg::DST_TA:    ta_q    <= res_q;
          rms_pkg::DST_TB:    tb_q    <= res_q;
          rms_pkg::DST_TC:    tc_q    <= res_q;
          rms_pkg::DST_TD:    td_q    <= res_q;
          rms_pkg::DST_PV:    pv_q    <= res_q;
          rms_pkg::DST_SP:    sp_q    <= res_q;
          rms_pkg::DST_VAR:   var_q   <= res_q;
          rms_pkg::DST_SDEV:  sdev_q  <= res_q;
          default: ;
        endcase
      end
      rms_pkg::ST_EMIT: begin
        if (emit_fire) begin
          out_code_q  <= code_q;
          out_value_q <= emit_val;
          out_last_q  <= (mask_hi[5:1] == '0);
        end
      end
      default: ;
    endcase
  end

  assign smp_i.ready       = (state_q == rms_pkg::ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.stat_code   = out_code_q;
  assign res_o.stat_value  = out_value_q;
  assign res_o.result_last = out_last_q;

  `RMS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_MAX)
  `RMS_ASSERT_IMP(a_code_enabled, clk_i, rst_ni, out_valid_q, mask_q[out_code_q])
  `RMS_ASSERT_IMP(a_step_bound, clk_i, rst_ni, state_q == rms_pkg::ST_ISSUE, step_q <= rms_pkg::STEP_OUT_LAST)

endmodule
